// ===== rtl/core/elrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elrc_pkg
// Types and constants shared by the event log ring blocks.
// ----------------------------------------------------------------------------
package elrc_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH     = 2'd0,
    ACT_FETCH    = 2'd1,
    ACT_COMMIT   = 2'd2,
    ACT_ROLLBACK = 2'd3
  } elrc_action_t;

  typedef enum logic [1:0] {
    CFG_MARKER_ID     = 2'd0,
    CFG_MARKER_TYPE   = 2'd1,
    CFG_MARKER_MODULE = 2'd2,
    CFG_MARKER_ERROR  = 2'd3
  } elrc_cfg_idx_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned INFO_W     = 48;

  localparam logic [15:0] MARKER_ID_RST     = 16'd1;
  localparam logic [7:0]  MARKER_TYPE_RST   = 8'd3;
  localparam logic [7:0]  MARKER_MODULE_RST = 8'd0;
  localparam logic [15:0] MARKER_ERROR_RST  = 16'd1;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] event_time;
    logic [7:0]  event_type;
    logic [7:0]  event_module;
    logic [15:0] event_id;
    logic [15:0] event_error;
  } elrc_in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] out_time;
    logic [7:0]  out_type;
    logic [7:0]  out_module;
    logic [15:0] out_id;
    logic [15:0] out_error;
    logic        overwrote;
    logic        is_empty;
  } elrc_out_t;

  typedef struct packed {
    logic time_we;
    logic info_we;
    logic rd_en;
  } elrc_mem_ctl_t;

  // entry info word: error [47:32], id [31:16], module [15:8], type [7:0]
  function automatic logic [INFO_W-1:0] pack_info(input logic [7:0]  typ,
                                                  input logic [7:0]  modl,
                                                  input logic [15:0] id,
                                                  input logic [15:0] err);
    return {err, id, modl, typ};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/elrc_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elrc_store
// Timestamp and info memories, one write port and one registered read port.
// ----------------------------------------------------------------------------
module elrc_store
  import elrc_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic                 clk,
  input  wire elrc_mem_ctl_t        mem_ctl,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [TIME_W-1:0]    wr_time,
  input  wire logic [INFO_W-1:0]    wr_info,
  input  wire logic [AW-1:0]        rd_addr,
  output logic      [TIME_W-1:0]    rd_time,
  output logic      [INFO_W-1:0]    rd_info
);

  logic [TIME_W-1:0] time_mem [DEPTH];
  logic [INFO_W-1:0] info_mem [DEPTH];
  logic [TIME_W-1:0] rd_time_r;
  logic [INFO_W-1:0] rd_info_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.time_we) begin
      time_mem[wr_addr] <= wr_time;
    end
    if (mem_ctl.rd_en) begin
      rd_time_r <= time_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.info_we) begin
      info_mem[wr_addr] <= wr_info;
    end
    if (mem_ctl.rd_en) begin
      rd_info_r <= info_mem[rd_addr];
    end
  end

  assign rd_time = rd_time_r;
  assign rd_info = rd_info_r;

endmodule
`default_nettype wire

// ===== rtl/core/elrc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elrc_ctrl
// Pointer state, marker registers and the sequencer that drives the store.
// ----------------------------------------------------------------------------
module elrc_ctrl
  import elrc_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned FW    = 7
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire elrc_in_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output elrc_out_t                   out_data,
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output elrc_mem_ctl_t               mem_ctl,
  output logic      [AW-1:0]          wr_addr,
  output logic      [TIME_W-1:0]      wr_time,
  output logic      [INFO_W-1:0]      wr_info,
  output logic      [AW-1:0]          rd_addr,
  input  wire logic [TIME_W-1:0]      rd_time,
  input  wire logic [INFO_W-1:0]      rd_info
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DROP,
    ST_MARK,
    ST_FETCH,
    ST_COMMIT,
    ST_DONE
  } state_t;

  localparam logic [AW-1:0] LAST_POS  = AW'(DEPTH - 1);
  localparam logic [FW-1:0] FREE_MAX  = FW'(DEPTH);
  localparam logic [FW-1:0] FREE_RST  = FW'(DEPTH - 1);

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
    return (p == LAST_POS) ? '0 : AW'(p + 1'b1);
  endfunction

  state_t          state_r, state_nxt;
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [AW-1:0]   cp_r, cp_nxt;
  logic [AW-1:0]   rp_r, rp_nxt;
  logic [FW-1:0]   free_r, free_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  elrc_out_t       res_r, res_nxt;
  elrc_out_t       out_data_r, out_data_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [15:0]     mk_id_r;
  logic [7:0]      mk_type_r;
  logic [7:0]      mk_module_r;
  logic [15:0]     mk_error_r;
  logic            in_take;
  logic            out_free;
  logic [AW-1:0]   wp_adv;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign wp_adv   = next_pos(wp_r);

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    cp_nxt        = cp_r;
    rp_nxt        = rp_r;
    free_nxt      = free_r;
    clr_nxt       = clr_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_ctl       = '0;
    wr_addr       = cp_r;
    wr_time       = '0;
    wr_info       = '0;
    rd_addr       = rp_r;

    unique case (state_r)
      ST_CLEAR: begin
        mem_ctl.time_we = 1'b1;
        mem_ctl.info_we = 1'b1;
        wr_addr         = clr_r;
        clr_nxt         = next_pos(clr_r);
        if (clr_r == LAST_POS) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_take) begin
          res_nxt = '0;
          unique case (in_data.action)
            ACT_PUSH: begin
              mem_ctl.time_we = 1'b1;
              mem_ctl.info_we = 1'b1;
              wr_addr         = wp_r;
              wr_time         = in_data.event_time;
              wr_info         = pack_info(in_data.event_type, in_data.event_module,
                                          in_data.event_id, in_data.event_error);
              if (free_r != '0) begin
                free_nxt = FW'(free_r - 1'b1);
              end
              wp_nxt    = wp_adv;
              state_nxt = (wp_adv == cp_r) ? ST_DROP : ST_DONE;
            end
            ACT_FETCH: begin
              mem_ctl.rd_en = 1'b1;
              state_nxt     = ST_FETCH;
            end
            ACT_COMMIT: begin
              state_nxt = ST_COMMIT;
            end
            ACT_ROLLBACK: begin
              rp_nxt    = cp_r;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_DROP: begin
        mem_ctl.time_we = 1'b1;
        mem_ctl.info_we = 1'b1;
        if (free_r < FREE_MAX) begin
          free_nxt = FW'(free_r + 1'b1);
        end
        cp_nxt    = next_pos(cp_r);
        state_nxt = ST_MARK;
      end
      ST_MARK: begin
        // marker keeps its timestamp
        mem_ctl.info_we   = 1'b1;
        wr_addr           = next_pos(cp_r);
        wr_info           = pack_info(mk_type_r, mk_module_r, mk_id_r, mk_error_r);
        res_nxt.overwrote = 1'b1;
        state_nxt         = ST_DONE;
      end
      ST_FETCH: begin
        if (rd_info[31:16] != '0) begin
          res_nxt.found      = 1'b1;
          res_nxt.out_time   = rd_time;
          res_nxt.out_type   = rd_info[7:0];
          res_nxt.out_module = rd_info[15:8];
          res_nxt.out_id     = rd_info[31:16];
          res_nxt.out_error  = rd_info[47:32];
          rp_nxt             = next_pos(rp_r);
        end
        state_nxt = ST_DONE;
      end
      ST_COMMIT: begin
        if (cp_r == rp_r) begin
          state_nxt = ST_DONE;
        end else begin
          mem_ctl.time_we = 1'b1;
          mem_ctl.info_we = 1'b1;
          if (free_r < FREE_MAX) begin
            free_nxt = FW'(free_r + 1'b1);
          end
          cp_nxt = next_pos(cp_r);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_nxt          = res_r;
          out_data_nxt.is_empty = (free_r >= FREE_RST);
          out_valid_nxt         = 1'b1;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      wp_r        <= LAST_POS;
      cp_r        <= LAST_POS;
      rp_r        <= LAST_POS;
      free_r      <= FREE_RST;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      cp_r        <= cp_nxt;
      rp_r        <= rp_nxt;
      free_r      <= free_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mk_id_r     <= MARKER_ID_RST;
      mk_type_r   <= MARKER_TYPE_RST;
      mk_module_r <= MARKER_MODULE_RST;
      mk_error_r  <= MARKER_ERROR_RST;
    end else if (cfg_valid) begin
      unique case (elrc_cfg_idx_t'(cfg_index))
        CFG_MARKER_ID:     mk_id_r     <= cfg_data;
        CFG_MARKER_TYPE:   mk_type_r   <= cfg_data[7:0];
        CFG_MARKER_MODULE: mk_module_r <= cfg_data[7:0];
        CFG_MARKER_ERROR:  mk_error_r  <= cfg_data;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/core/event_log_ring_with_commit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// event_log_ring_with_commit
// Overwriting event log ring with fetch, commit and rollback access.
//
// channel   direction  handshake          payload
// in_       input      in_valid/in_stall  elrc_in_t  (action and event)
// out_      output     out_valid/out_stall elrc_out_t (one per transaction)
// cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data (marker regs)
//
// push writes the entry; when it overwrites the oldest entry it also clears it and writes a marker
// fetch does one memory read with registered data
// rollback moves the read pointer back to the commit point; commit clears entries one by one up to the read pointer
// after reset a clearing pass writes every entry with in_stall high
// a finished result waits in the output register; out_stall holds it there
// ----------------------------------------------------------------------------
module event_log_ring_with_commit
  import elrc_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire elrc_in_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output elrc_out_t                   out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);

  elrc_mem_ctl_t       mem_ctl;
  logic [AW-1:0]       wr_addr;
  logic [TIME_W-1:0]   wr_time;
  logic [INFO_W-1:0]   wr_info;
  logic [AW-1:0]       rd_addr;
  logic [TIME_W-1:0]   rd_time;
  logic [INFO_W-1:0]   rd_info;

  assign cfg_ready = 1'b1;

  elrc_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .FW    (FW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mem_ctl   (mem_ctl),
    .wr_addr   (wr_addr),
    .wr_time   (wr_time),
    .wr_info   (wr_info),
    .rd_addr   (rd_addr),
    .rd_time   (rd_time),
    .rd_info   (rd_info)
  );

  elrc_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .wr_addr (wr_addr),
    .wr_time (wr_time),
    .wr_info (wr_info),
    .rd_addr (rd_addr),
    .rd_time (rd_time),
    .rd_info (rd_info)
  );

endmodule
`default_nettype wire

// ===== rtl/core/elrc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elrc_checker
// Port-level checks for the event log ring, bound to the top level.
// ----------------------------------------------------------------------------
module elrc_checker
  import elrc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire elrc_out_t  out_data
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one transaction in flight at a time
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on back-to-back cycles");

  // a fetch never overflows the ring
  a_found_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.found && out_data.overwrote))
    else $error("found and overwrote both set");

  // a found entry has a nonzero id
  a_found_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.out_id != '0)
    else $error("found entry with empty id");

  // no entry means zero payload
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |->
      out_data.out_time == '0 && out_data.out_id == '0 && out_data.out_error == '0)
    else $error("payload set without found");

endmodule

bind event_log_ring_with_commit elrc_checker u_elrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// ===== verif/event_log_ring_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_log_ring_checker
// Watches the input, result and marker register channels of the event log
// ring. Keeps its own copy of the ring, pointers, free count and marker
// registers, works out the result of every accepted transaction and compares
// each accepted result field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module event_log_ring_checker
  import elrc_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire elrc_in_t              in_data,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire elrc_out_t             out_data,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending_count,
  output int                         hit_count,
  output int                         overflow_count
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  typedef struct packed {
    logic [15:0] err;
    logic [15:0] id;
    logic [7:0]  modl;
    logic [7:0]  typ;
  } entry_info_t;

  logic [31:0]      time_mem [DEPTH];
  entry_info_t      info_mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] cm_ptr;
  logic [PTR_W-1:0] rd_ptr;
  int unsigned      free_cnt;
  logic [15:0]      mark_id;
  logic [7:0]       mark_type;
  logic [7:0]       mark_module;
  logic [15:0]      mark_err;

  elrc_out_t   fetch_results_q [$];
  elrc_out_t   want;
  int unsigned result_idx;

  initial begin
    fail_count     = 0;
    pending_count  = 0;
    hit_count      = 0;
    overflow_count = 0;
    result_idx     = 0;
  end

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (fail_count < 40)
      $display("mismatch at result %0d: %s got %h want %h", result_idx, what, got, exp_val);
    fail_count++;
  endtask

  // clear one entry, count it free and move the commit pointer on
  task automatic drop_entry(input logic [PTR_W-1:0] p);
    time_mem[p] = '0;
    info_mem[p] = '0;
    if (free_cnt < DEPTH)
      free_cnt++;
    cm_ptr = ring_next(cm_ptr);
  endtask

  task automatic log_ring_step(input elrc_in_t item, output elrc_out_t res);
    logic [PTR_W-1:0] p;
    int               n;
    res = '0;
    case (elrc_action_t'(item.action))
      ACT_PUSH: begin
        time_mem[wr_ptr] = item.event_time;
        info_mem[wr_ptr] = {item.event_error, item.event_id, item.event_module,
                            item.event_type};
        if (free_cnt > 0)
          free_cnt--;
        wr_ptr = ring_next(wr_ptr);
        if (wr_ptr == cm_ptr) begin
          drop_entry(cm_ptr);
          info_mem[ring_next(cm_ptr)] = {mark_err, mark_id, mark_module, mark_type};
          res.overwrote = 1'b1;
          overflow_count++;
        end
      end
      ACT_FETCH: begin
        if (info_mem[rd_ptr].id != 16'd0) begin
          res.found      = 1'b1;
          res.out_time   = time_mem[rd_ptr];
          res.out_type   = info_mem[rd_ptr].typ;
          res.out_module = info_mem[rd_ptr].modl;
          res.out_id     = info_mem[rd_ptr].id;
          res.out_error  = info_mem[rd_ptr].err;
          rd_ptr         = ring_next(rd_ptr);
          hit_count++;
        end
      end
      ACT_COMMIT: begin
        p = cm_ptr;
        for (n = 0; n < DEPTH && p != rd_ptr; n++) begin
          drop_entry(p);
          p = ring_next(p);
        end
        cm_ptr = rd_ptr;
      end
      default: begin
        rd_ptr = cm_ptr;
      end
    endcase
    res.is_empty = (free_cnt >= DEPTH - 1);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        time_mem[i] = '0;
        info_mem[i] = '0;
      end
      wr_ptr      = LAST_PTR;
      cm_ptr      = LAST_PTR;
      rd_ptr      = LAST_PTR;
      free_cnt    = DEPTH - 1;
      mark_id     = MARKER_ID_RST;
      mark_type   = MARKER_TYPE_RST;
      mark_module = MARKER_MODULE_RST;
      mark_err    = MARKER_ERROR_RST;
      fetch_results_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (fetch_results_q.size() == 0) begin
          report_mismatch("unexpected transaction", out_data[31:0], '0);
        end else begin
          want = fetch_results_q.pop_front();
          if (out_data.found !== want.found)
            report_mismatch("found", out_data.found, want.found);
          if (out_data.out_time !== want.out_time)
            report_mismatch("out_time", out_data.out_time, want.out_time);
          if (out_data.out_type !== want.out_type)
            report_mismatch("out_type", out_data.out_type, want.out_type);
          if (out_data.out_module !== want.out_module)
            report_mismatch("out_module", out_data.out_module, want.out_module);
          if (out_data.out_id !== want.out_id)
            report_mismatch("out_id", out_data.out_id, want.out_id);
          if (out_data.out_error !== want.out_error)
            report_mismatch("out_error", out_data.out_error, want.out_error);
          if (out_data.overwrote !== want.overwrote)
            report_mismatch("overwrote", out_data.overwrote, want.overwrote);
          if (out_data.is_empty !== want.is_empty)
            report_mismatch("is_empty", out_data.is_empty, want.is_empty);
        end
        result_idx++;
      end
      if (cfg_valid && cfg_ready) begin
        case (elrc_cfg_idx_t'(cfg_index))
          CFG_MARKER_ID:     mark_id     = cfg_data[15:0];
          CFG_MARKER_TYPE:   mark_type   = cfg_data[7:0];
          CFG_MARKER_MODULE: mark_module = cfg_data[7:0];
          default:           mark_err    = cfg_data[15:0];
        endcase
      end
      if (in_valid && !in_stall) begin
        log_ring_step(in_data, want);
        fetch_results_q.push_back(want);
      end
    end
    pending_count <= fetch_results_q.size();
  end

endmodule

// ===== verif/event_log_ring_with_commit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_log_ring_with_commit_tb
// Drives pushes, fetches, commits and rollbacks into the event log ring under
// three stall profiles and several marker register settings, starting with a
// short directed sequence and then random transaction sequences that include
// ring overflows and commits that walk the whole ring. A checker module
// predicts and compares every result; this top gives the verdict.
// ----------------------------------------------------------------------------
module event_log_ring_with_commit_tb;
  import elrc_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned PHASE_ITEMS = 530;
  localparam int unsigned STALL_LIMIT = 1000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  elrc_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  elrc_out_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int unsigned sent_count    = 0;
  int unsigned cfg_count     = 0;
  int unsigned idle_cycles   = 0;
  int          fail_count;
  int          pending_count;
  int          hit_count;
  int          overflow_count;

  event_log_ring_with_commit #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  event_log_ring_checker #(.DEPTH(DEPTH)) log_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .hit_count      (hit_count),
    .overflow_count (overflow_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // cycles with no transaction on any channel
  initial begin
    wait (rst_n === 1'b1);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic elrc_in_t make_event(input elrc_action_t act, input logic [31:0] t,
                                          input logic [7:0] ty, input logic [7:0] md,
                                          input logic [15:0] id, input logic [15:0] er);
    elrc_in_t it;
    it.action       = act;
    it.event_time   = t;
    it.event_type   = ty;
    it.event_module = md;
    it.event_id     = id;
    it.event_error  = er;
    return it;
  endfunction

  task automatic send_item(input elrc_in_t item);
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic send_random(input elrc_action_t act);
    logic [31:0] t;
    logic [15:0] id;
    int          r;
    r = $urandom_range(15);
    t = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
    r = $urandom_range(31);
    id = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(65535, 1));
    send_item(make_event(act, t, 8'($urandom), 8'($urandom), id, 16'($urandom)));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input elrc_cfg_idx_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_count++;
  endtask

  task automatic run_random(input int unsigned quota);
    int unsigned stop_at;
    int          r;
    int          n;
    stop_at = sent_count + quota;
    while (sent_count < stop_at) begin
      r = $urandom_range(99);
      if (r < 8) begin
        n = $urandom_range(6, 1);
        repeat (n) send_random(elrc_action_t'($urandom_range(3)));
      end else if (r < 14) begin
        // fill past the commit point, then either walk the ring or re-read
        send_random(ACT_COMMIT);
        n = $urandom_range(70, 62);
        repeat (n) send_random(ACT_PUSH);
        if ($urandom_range(1)) begin
          send_random(ACT_COMMIT);
        end else begin
          n = $urandom_range(4, 1);
          repeat (n) send_random(ACT_FETCH);
          send_random(ACT_ROLLBACK);
        end
      end else begin
        n = $urandom_range(8, 1);
        repeat (n) send_random(ACT_PUSH);
        n = $urandom_range(10, 1);
        repeat (n) send_random(ACT_FETCH);
        r = $urandom_range(99);
        if (r < 60) begin
          send_random(ACT_COMMIT);
        end else if (r < 85) begin
          send_random(ACT_ROLLBACK);
          n = $urandom_range(3, 1);
          repeat (n) send_random(ACT_FETCH);
          send_random(ACT_COMMIT);
        end
      end
      if ($urandom_range(99) < 4)
        drain();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_MARKER_ID, 16'd1);
    write_reg(CFG_MARKER_TYPE, 16'd0);
    write_reg(CFG_MARKER_MODULE, 16'd0);
    write_reg(CFG_MARKER_ERROR, 16'd0);
    send_idle_pct = 19;
    recv_idle_pct = 66;

    // empty ring, then field extremes and an id-zero entry
    send_item(make_event(ACT_FETCH, '0, '0, '0, '0, '0));
    send_item(make_event(ACT_COMMIT, '0, '0, '0, '0, '0));
    send_item(make_event(ACT_ROLLBACK, '1, '1, '1, '1, '1));
    send_item(make_event(ACT_PUSH, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_item(make_event(ACT_PUSH, 32'd0, 8'd0, 8'd0, 16'd1, 16'd0));
    send_item(make_event(ACT_PUSH, 32'h1234_5678, 8'h5A, 8'hA5, 16'd0, 16'hBEEF));
    send_item(make_event(ACT_PUSH, 32'h8000_0001, 8'h80, 8'h01, 16'h8000, 16'h0001));
    send_item(make_event(ACT_FETCH, '0, '0, '0, '0, '0));
    send_item(make_event(ACT_FETCH, '1, '1, '1, '1, '1));
    send_item(make_event(ACT_FETCH, '0, '0, '0, '0, '0));
    send_item(make_event(ACT_FETCH, '0, '0, '0, '0, '0));
    send_item(make_event(ACT_ROLLBACK, '0, '0, '0, '0, '0));
    send_item(make_event(ACT_FETCH, '0, '0, '0, '0, '0));
    send_item(make_event(ACT_COMMIT, '0, '0, '0, '0, '0));
    send_item(make_event(ACT_FETCH, '0, '0, '0, '0, '0));
    send_item(make_event(ACT_COMMIT, '0, '0, '0, '0, '0));
    send_item(make_event(ACT_PUSH, 32'd0, 8'h01, 8'h80, 16'h7FFF, 16'hFFFF));
    send_item(make_event(ACT_FETCH, '0, '0, '0, '0, '0));
    run_random(PHASE_ITEMS);
    drain();

    write_reg(CFG_MARKER_ID, 16'hFFFF);
    write_reg(CFG_MARKER_TYPE, 16'h00FF);
    write_reg(CFG_MARKER_MODULE, 16'h00FF);
    write_reg(CFG_MARKER_ERROR, 16'hFFFF);
    send_idle_pct = 66;
    recv_idle_pct = 19;
    run_random(PHASE_ITEMS);
    drain();

    write_reg(CFG_MARKER_ID, 16'($urandom_range(65535, 1)));
    write_reg(CFG_MARKER_TYPE, 16'($urandom_range(255)));
    write_reg(CFG_MARKER_MODULE, 16'($urandom_range(255)));
    write_reg(CFG_MARKER_ERROR, 16'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_ITEMS);
    drain();
    repeat (16) @(posedge clk);

    $display("covered %0d transactions under three stall profiles, %0d marker writes",
             sent_count, cfg_count);
    $display("%0d fetches returned entries, %0d pushes overflowed the ring",
             hit_count, overflow_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/elrc_pkg.sv
rtl/core/elrc_store.sv
rtl/core/elrc_ctrl.sv
rtl/core/event_log_ring_with_commit.sv
rtl/core/elrc_checker.sv
verif/event_log_ring_checker.sv
verif/event_log_ring_with_commit_tb.sv
